FILE: hdl/toy_language_lexer_assert.svh
// Assertion macros used by the lexer checker.
`ifndef TOY_LANGUAGE_LEXER_ASSERT_SVH
`define TOY_LANGUAGE_LEXER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TLL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lexer check failed: same-cycle rule");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TLL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lexer check failed: next-cycle rule");

`endif

FILE: hdl/tll_pkg.sv
// Shared types, constants and character-class functions of the lexer.
package tll_pkg;

	// Width of the internal token length counter.
	localparam int LEN_BITS = 16;
	localparam int NKW      = 12;

	// Output queue geometry.
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [4:0] {
		KIND_IDENT   = 5'd0,
		KIND_INT     = 5'd1,
		KIND_FLOAT   = 5'd2,
		KIND_STRING  = 5'd3,
		KIND_BOOL    = 5'd4,
		KIND_TYPE    = 5'd5,
		KIND_FNC     = 5'd6,
		KIND_EXTERN  = 5'd7,
		KIND_OPDEF   = 5'd8,
		KIND_IF      = 5'd9,
		KIND_ELSE    = 5'd10,
		KIND_RET     = 5'd11,
		KIND_OPER    = 5'd12,
		KIND_LPAREN  = 5'd13,
		KIND_RPAREN  = 5'd14,
		KIND_LBRACE  = 5'd15,
		KIND_RBRACE  = 5'd16,
		KIND_ASSIGN  = 5'd17,
		KIND_SEMI    = 5'd18,
		KIND_BAD     = 5'd19,
		KIND_UNTERM  = 5'd20
	} tll_kind_t;

	// Detail codes.
	localparam logic [1:0] DET_NONE   = 2'd0;
	localparam logic [1:0] TYPE_INT   = 2'd0;
	localparam logic [1:0] TYPE_FLOAT = 2'd1;
	localparam logic [1:0] TYPE_BOOL  = 2'd2;
	localparam logic [1:0] TYPE_STR   = 2'd3;
	localparam logic [1:0] BOOL_FALSE = 2'd0;
	localparam logic [1:0] BOOL_TRUE  = 2'd1;

	// Lexer modes, one-hot.
	typedef enum logic [4:0] {
		M_IDLE   = 5'b00001,
		M_STRING = 5'b00010,
		M_OPER   = 5'b00100,
		M_IDENT  = 5'b01000,
		M_NUMBER = 5'b10000
	} tll_mode_t;

	// Characters with a role of their own.
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;

	// Keyword text, first byte in the top byte, padded with zeros.
	localparam logic [63:0] KW_TEXT [NKW] = '{
		{"fnc", 40'h0}, {"extern", 16'h0}, "operator", {"int", 40'h0},
		{"float", 24'h0}, {"bool", 32'h0}, {"str", 40'h0}, {"true", 32'h0},
		{"false", 24'h0}, {"if", 48'h0}, {"else", 32'h0}, {"ret", 40'h0}
	};
	localparam logic [3:0] KW_LEN [NKW] = '{
		4'd3, 4'd6, 4'd8, 4'd3, 4'd5, 4'd4, 4'd3, 4'd4, 4'd5, 4'd2, 4'd4, 4'd3
	};
	localparam tll_kind_t KW_KIND [NKW] = '{
		KIND_FNC, KIND_EXTERN, KIND_OPDEF, KIND_TYPE, KIND_TYPE, KIND_TYPE,
		KIND_TYPE, KIND_BOOL, KIND_BOOL, KIND_IF, KIND_ELSE, KIND_RET
	};
	localparam logic [1:0] KW_DETAIL [NKW] = '{
		DET_NONE, DET_NONE, DET_NONE, TYPE_INT, TYPE_FLOAT, TYPE_BOOL,
		TYPE_STR, BOOL_TRUE, BOOL_FALSE, DET_NONE, DET_NONE, DET_NONE
	};

	// One token record as it leaves the block.
	typedef struct packed {
		tll_kind_t             kind;
		logic [1:0]            detail;
		logic [31:0]           start;
		logic [15:0]           length;
		logic                  last;
	} tll_result_t;

	// Records made by one accepted byte, handed to the output queue.
	typedef struct packed {
		logic [1:0]  count;
		tll_result_t r0;
		tll_result_t r1;
	} tll_push_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// Operator characters: ! ~ @ # $ % ^ & * - + \ / < >
	function automatic logic is_op(input logic [7:0] c);
		logic r;
		case (c)
			8'h21, 8'h7E, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26,
			8'h2A, 8'h2D, 8'h2B, 8'h5C, 8'h2F, 8'h3C, 8'h3E: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Kind of a byte that stands alone: a mark or a bad byte.
	function automatic tll_kind_t single_kind(input logic [7:0] c);
		tll_kind_t k;
		case (c)
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_LBRACE: k = KIND_LBRACE;
			CH_RBRACE: k = KIND_RBRACE;
			CH_EQUAL:  k = KIND_ASSIGN;
			CH_SEMI:   k = KIND_SEMI;
			default:   k = KIND_BAD;
		endcase
		return k;
	endfunction

	// Keep the keywords whose byte at position idx equals c.
	function automatic logic [NKW-1:0] kw_filter(input logic [NKW-1:0] mask,
			input logic [LEN_BITS-1:0] idx, input logic [7:0] c);
		logic [NKW-1:0] res;
		logic [2:0]     idx3;
		res  = '0;
		idx3 = idx[2:0];
		for (int k = 0; k < NKW; k++) begin
			if (mask[k] && (idx < LEN_BITS'(KW_LEN[k])) &&
					(KW_TEXT[k][{~idx3, 3'b000} +: 8] == c)) begin
				res[k] = 1'b1;
			end
		end
		return res;
	endfunction

	// Saturating increment of the length counter.
	function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] len);
		return (&len) ? len : len + LEN_BITS'(1);
	endfunction

	// Record of the token pending in a mode; last_of_run is set later.
	function automatic tll_result_t finish_rec(input tll_mode_t mode, input logic at_end,
			input logic saw_dot, input logic [NKW-1:0] cand,
			input logic [LEN_BITS-1:0] len, input logic [31:0] start);
		tll_result_t r;
		r.kind   = KIND_IDENT;
		r.detail = DET_NONE;
		r.start  = start;
		// The reported length saturates at the top of its 16-bit field.
		r.length = (32'(len) > 32'd65535) ? 16'hFFFF : 16'(len);
		r.last   = 1'b0;
		case (mode)
			M_STRING: r.kind = at_end ? KIND_UNTERM : KIND_STRING;
			M_OPER:   r.kind = KIND_OPER;
			M_NUMBER: r.kind = saw_dot ? KIND_FLOAT : KIND_INT;
			M_IDENT: begin
				// The lowest-numbered keyword of the right length wins.
				for (int k = NKW - 1; k >= 0; k--) begin
					if (cand[k] && (len == LEN_BITS'(KW_LEN[k]))) begin
						r.kind   = KW_KIND[k];
						r.detail = KW_DETAIL[k];
					end
				end
			end
			default: r.kind = KIND_IDENT;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/tll_if.sv
// Channel interfaces: source bytes in, token words out.
interface tll_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       is_last;

	modport source (output valid, output char_in, output is_last, input ready);
	modport sink (input valid, input char_in, input is_last, output ready);
endinterface

interface tll_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [1:0]  kind_detail;
	logic [31:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	modport source (output valid, output token_kind, output kind_detail,
		output token_start, output token_length, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input kind_detail,
		input token_start, input token_length, input last_of_run, output ready);
endinterface

FILE: hdl/tll_core.sv
// Lexer state registers and the per-byte token decision.
module tll_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          char_in,
	input  logic                is_last,
	output tll_pkg::tll_push_t  push
);

	tll_pkg::tll_mode_t                mode_q, mode_d;
	logic                              saw_dot_q, saw_dot_d;
	logic [tll_pkg::NKW-1:0]           cand_q, cand_d;
	logic [tll_pkg::LEN_BITS-1:0]      len_q, len_d;
	logic [31:0]                       start_q, start_d;
	logic [31:0]                       pos_q, pos_d;

	logic                              taken;
	logic                              fin_v, pun_v, end_v;
	tll_pkg::tll_result_t              fin_r, pun_r, end_r;
	logic [1:0]                        cnt;

	// Next state and the records one byte makes.
	always_comb begin
		mode_d    = mode_q;
		saw_dot_d = saw_dot_q;
		cand_d    = cand_q;
		len_d     = len_q;
		start_d   = start_q;
		pos_d     = pos_q + 32'd1;
		taken     = 1'b0;
		fin_v     = 1'b0;
		pun_v     = 1'b0;
		end_v     = 1'b0;
		fin_r     = tll_pkg::finish_rec(mode_q, 1'b0, saw_dot_q, cand_q, len_q, start_q);

		// Continue or close the pending token.
		unique case (mode_q)
			tll_pkg::M_STRING: begin
				if (char_in == tll_pkg::CH_QUOTE) begin
					fin_v  = 1'b1;
					mode_d = tll_pkg::M_IDLE;
				end else begin
					len_d = tll_pkg::len_inc(len_q);
				end
				taken = 1'b1;
			end
			tll_pkg::M_OPER: begin
				if (tll_pkg::is_op(char_in)) begin
					len_d = tll_pkg::len_inc(len_q);
					taken = 1'b1;
				end else begin
					fin_v  = 1'b1;
					mode_d = tll_pkg::M_IDLE;
				end
			end
			tll_pkg::M_IDENT: begin
				if (tll_pkg::is_alpha(char_in) || tll_pkg::is_digit(char_in) ||
						char_in == tll_pkg::CH_UNDER) begin
					cand_d = tll_pkg::kw_filter(cand_q, len_q, char_in);
					len_d  = tll_pkg::len_inc(len_q);
					taken  = 1'b1;
				end else begin
					fin_v  = 1'b1;
					mode_d = tll_pkg::M_IDLE;
				end
			end
			tll_pkg::M_NUMBER: begin
				if (tll_pkg::is_digit(char_in) || char_in == tll_pkg::CH_DOT) begin
					if (char_in == tll_pkg::CH_DOT) begin
						saw_dot_d = 1'b1;
					end
					len_d = tll_pkg::len_inc(len_q);
					taken = 1'b1;
				end else begin
					fin_v  = 1'b1;
					mode_d = tll_pkg::M_IDLE;
				end
			end
			default: mode_d = tll_pkg::M_IDLE;
		endcase

		// Open a new token, or report a mark or a bad byte on its own.
		pun_r.kind   = tll_pkg::single_kind(char_in);
		pun_r.detail = tll_pkg::DET_NONE;
		pun_r.start  = pos_q;
		pun_r.length = 16'd1;
		pun_r.last   = 1'b0;
		if (!taken && !tll_pkg::is_space(char_in)) begin
			start_d = pos_q;
			len_d   = tll_pkg::LEN_BITS'(1);
			if (char_in == tll_pkg::CH_QUOTE) begin
				mode_d  = tll_pkg::M_STRING;
				start_d = pos_q + 32'd1;
				len_d   = '0;
			end else if (tll_pkg::is_op(char_in)) begin
				mode_d = tll_pkg::M_OPER;
			end else if (tll_pkg::is_alpha(char_in) || char_in == tll_pkg::CH_UNDER) begin
				mode_d = tll_pkg::M_IDENT;
				cand_d = tll_pkg::kw_filter('1, '0, char_in);
			end else if (tll_pkg::is_digit(char_in)) begin
				mode_d    = tll_pkg::M_NUMBER;
				saw_dot_d = 1'b0;
			end else begin
				pun_v = 1'b1;
			end
		end

		// End of text flushes whatever is still open and clears the state.
		end_r = tll_pkg::finish_rec(mode_d, 1'b1, saw_dot_d, cand_d, len_d, start_d);
		if (is_last) begin
			end_v     = (mode_d != tll_pkg::M_IDLE);
			mode_d    = tll_pkg::M_IDLE;
			saw_dot_d = 1'b0;
			cand_d    = '0;
			len_d     = '0;
			start_d   = '0;
			pos_d     = '0;
		end
	end

	// Pack the records in order; a mark and an end-of-text flush never meet.
	always_comb begin
		cnt        = 2'({1'b0, fin_v} + {1'b0, pun_v} + {1'b0, end_v});
		push.r0    = fin_v ? fin_r : (pun_v ? pun_r : end_r);
		push.r1    = pun_v ? pun_r : end_r;
		push.r0.last = (cnt == 2'd1);
		push.r1.last = 1'b1;
		push.count = accept ? cnt : 2'd0;
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= tll_pkg::M_IDLE;
			saw_dot_q <= 1'b0;
			cand_q    <= '0;
			len_q     <= '0;
			start_q   <= '0;
			pos_q     <= '0;
		end else if (accept) begin
			mode_q    <= mode_d;
			saw_dot_q <= saw_dot_d;
			cand_q    <= cand_d;
			len_q     <= len_d;
			start_q   <= start_d;
			pos_q     <= pos_d;
		end
	end

endmodule

FILE: hdl/tll_queue.sv
// Small output queue that takes up to two token words a cycle and gives one.
module tll_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  tll_pkg::tll_push_t  push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output tll_pkg::tll_result_t out_word
);

	tll_pkg::tll_result_t               mem_q [tll_pkg::QDEPTH];
	logic [tll_pkg::QPTR_W-1:0]         wr_ptr_q, rd_ptr_q;
	logic [tll_pkg::QCNT_W-1:0]         count_q;
	logic                               pop;
	logic [tll_pkg::QPTR_W-1:0]         wr_ptr_nx;

	// Room for the two words one byte may make.
	assign room      = (count_q <= tll_pkg::QCNT_W'(tll_pkg::QDEPTH - 2));
	assign out_valid = (count_q != '0);
	assign out_word  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign wr_ptr_nx = wr_ptr_q + tll_pkg::QPTR_W'(1);

	// Storage: words are written in order at the tail.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + tll_pkg::QPTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + tll_pkg::QPTR_W'(1);
			end
			count_q <= count_q + tll_pkg::QCNT_W'(push.count) -
				tll_pkg::QCNT_W'(pop);
		end
	end

endmodule

FILE: hdl/toy_language_lexer.sv
// Top level of the streaming lexer for the toy language.
//
//   channel | dir | word                                      | handshake
//   text    | in  | char_in, is_last                          | valid/ready
//   tokens  | out | token_kind, kind_detail, token_start,     | valid/ready
//           |     | token_length, last_of_run                 |
//
// One source byte is taken every cycle while the output queue has room.
// Each byte updates the mode register and keyword mask when it is accepted; its
// tokens (none, one or two) enter the output queue and leave on the tokens channel in order.
// The four-word output queue drives text.ready low once three words wait.
// Reset clears the lexer state, the byte position and the queue.
module toy_language_lexer (
	input  logic      clk,
	input  logic      arst_n,
	tll_in_if.sink    text,
	tll_out_if.source tokens
);

	logic                 accept;
	logic                 room;
	tll_pkg::tll_push_t   push;
	tll_pkg::tll_result_t head;

	assign text.ready = room;
	assign accept     = text.valid && room;

	// Per-byte decision and lexer state.
	tll_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.char_in (text.char_in),
		.is_last (text.is_last),
		.push    (push)
	);

	// Token words waiting for the sink.
	tll_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (tokens.valid),
		.out_ready (tokens.ready),
		.out_word  (head)
	);

	// Unpack the head word onto the channel.
	assign tokens.token_kind   = head.kind;
	assign tokens.kind_detail  = head.detail;
	assign tokens.token_start  = head.start;
	assign tokens.token_length = head.length;
	assign tokens.last_of_run  = head.last;

endmodule

FILE: hdl/tll_checker.sv
// Port-level checks on the token channel, bound to the lexer top level.
`include "toy_language_lexer_assert.svh"

module tll_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        tok_valid,
	input logic        tok_ready,
	input logic [4:0]  tok_kind,
	input logic [1:0]  tok_detail,
	input logic [31:0] tok_start,
	input logic [15:0] tok_length,
	input logic        tok_last
);

	logic [55:0] tok_word;
	logic        tok_single;
	logic        tok_plain;
	logic        tok_typed;

	// Whole payload, and the token classes the rules below talk about.
	assign tok_word   = {tok_kind, tok_detail, tok_start, tok_length, tok_last};
	assign tok_single = (tok_kind >= tll_pkg::KIND_LPAREN) && (tok_kind <= tll_pkg::KIND_BAD);
	assign tok_plain  = (tok_length == 16'd1) && (tok_detail == tll_pkg::DET_NONE);
	assign tok_typed  = (tok_kind == tll_pkg::KIND_TYPE) || (tok_kind == tll_pkg::KIND_BOOL);

	// A stalled word stays offered.
	`TLL_ASSERT_NEXT(a_valid_holds, clk, arst_n, tok_valid && !tok_ready, tok_valid)

	// A stalled word keeps its payload.
	`TLL_ASSERT_NEXT(a_word_holds, clk, arst_n, tok_valid && !tok_ready, $stable(tok_word))

	// Marks and bad bytes are single-byte tokens with no detail.
	`TLL_ASSERT_NOW(a_single_len, clk, arst_n, tok_valid && tok_single, tok_plain)

	// Only type and bool tokens carry a detail code.
	`TLL_ASSERT_NOW(a_detail_kind, clk, arst_n, tok_valid && tok_detail != 2'd0, tok_typed)

endmodule

bind toy_language_lexer tll_checker u_tll_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tok_valid  (tokens.valid),
	.tok_ready  (tokens.ready),
	.tok_kind   (tokens.token_kind),
	.tok_detail (tokens.kind_detail),
	.tok_start  (tokens.token_start),
	.tok_length (tokens.token_length),
	.tok_last   (tokens.last_of_run)
);

FILE: tb/toy_language_lexer_tb.sv
// Testbench for the toy language lexer: random and directed text against a token predictor.
module toy_language_lexer_tb;
	import tll_pkg::*;

	// One source byte waiting to be sent, with the idle cycles that come before it.
	typedef struct {
		logic [7:0]  ch;
		logic        end_flag;
		int unsigned gap;
	} src_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tll_in_if  text_ch ();
	tll_out_if token_ch ();

	toy_language_lexer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.tokens (token_ch)
	);

	always #6 clk = ~clk;

	// Keyword table of the language, in priority order.
	string      kw_word  [NKW] = '{"fnc", "extern", "operator", "int", "float", "bool",
		"str", "true", "false", "if", "else", "ret"};
	tll_kind_t  kw_class [NKW] = '{KIND_FNC, KIND_EXTERN, KIND_OPDEF, KIND_TYPE, KIND_TYPE,
		KIND_TYPE, KIND_TYPE, KIND_BOOL, KIND_BOOL, KIND_IF, KIND_ELSE, KIND_RET};
	logic [1:0] kw_code  [NKW] = '{DET_NONE, DET_NONE, DET_NONE, TYPE_INT, TYPE_FLOAT,
		TYPE_BOOL, TYPE_STR, BOOL_TRUE, BOOL_FALSE, DET_NONE, DET_NONE, DET_NONE};

	string oper_set   = "!~@#$%^&*-+\\/<>";
	string mark_chars = "(){}=;";

	src_byte_t   pending [$];
	tll_result_t token_fifo [$];
	int unsigned mismatches = 0;
	logic        src_busy = 1'b0;

	// Predictor state, one copy of what the lexer keeps between bytes.
	tll_mode_t      lx_mode = M_IDLE;
	logic           lx_dot = 1'b0;
	logic [NKW-1:0] lx_cand = '0;
	logic [15:0]    lx_len = '0;
	logic [31:0]    lx_start = '0;
	logic [31:0]    lx_pos = '0;

	function automatic logic blank_byte(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic letter_byte(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic digit_byte(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic opchar_byte(input logic [7:0] c);
		for (int i = 0; i < oper_set.len(); i++) begin
			if (oper_set[i] == c) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic tll_kind_t mark_kind(input logic [7:0] c);
		case (c)
			CH_LPAREN: return KIND_LPAREN;
			CH_RPAREN: return KIND_RPAREN;
			CH_LBRACE: return KIND_LBRACE;
			CH_RBRACE: return KIND_RBRACE;
			CH_EQUAL:  return KIND_ASSIGN;
			CH_SEMI:   return KIND_SEMI;
			default:   return KIND_BAD;
		endcase
	endfunction

	// Keywords that still match after byte c at position idx.
	function automatic logic [NKW-1:0] narrow_keywords(input logic [NKW-1:0] mask,
			input logic [15:0] idx, input logic [7:0] c);
		logic [NKW-1:0] res;
		res = '0;
		for (int k = 0; k < NKW; k++) begin
			if (mask[k] && int'(idx) < kw_word[k].len() && kw_word[k][int'(idx)] == c)
				res[k] = 1'b1;
		end
		return res;
	endfunction

	function automatic tll_result_t token_rec(input tll_kind_t kind, input logic [1:0] detail,
			input logic [31:0] start, input logic [15:0] len);
		tll_result_t r;
		r.kind   = kind;
		r.detail = detail;
		r.start  = start;
		r.length = len;
		r.last   = 1'b0;
		return r;
	endfunction

	// Closes the pending token, if any; returns 1 when a record was made.
	function automatic logic close_token(input logic at_end, output tll_result_t r);
		tll_kind_t  kind;
		logic [1:0] detail;
		kind   = KIND_IDENT;
		detail = DET_NONE;
		case (lx_mode)
			M_STRING: kind = at_end ? KIND_UNTERM : KIND_STRING;
			M_OPER:   kind = KIND_OPER;
			M_NUMBER: kind = lx_dot ? KIND_FLOAT : KIND_INT;
			M_IDENT: begin
				for (int k = NKW - 1; k >= 0; k--) begin
					if (lx_cand[k] && int'(lx_len) == kw_word[k].len()) begin
						kind   = kw_class[k];
						detail = kw_code[k];
					end
				end
			end
			default: return 1'b0;
		endcase
		r = token_rec(kind, detail, lx_start, lx_len);
		lx_mode = M_IDLE;
		return 1'b1;
	endfunction

	// Works out the tokens that one accepted byte yields and queues them.
	function automatic void lex_byte(input logic [7:0] c, input logic end_flag);
		tll_result_t made [2];
		tll_result_t r;
		int          n;
		logic [31:0] pos;
		logic        taken;
		n     = 0;
		pos   = lx_pos;
		taken = 1'b0;
		case (lx_mode)
			M_STRING: begin
				if (c == CH_QUOTE) begin
					if (close_token(1'b0, r)) made[n++] = r;
				end else if (!(&lx_len)) begin
					lx_len++;
				end
				taken = 1'b1;
			end
			M_OPER: begin
				if (opchar_byte(c)) begin
					if (!(&lx_len)) lx_len++;
					taken = 1'b1;
				end else if (close_token(1'b0, r)) begin
					made[n++] = r;
				end
			end
			M_IDENT: begin
				if (letter_byte(c) || digit_byte(c) || c == CH_UNDER) begin
					lx_cand = narrow_keywords(lx_cand, lx_len, c);
					if (!(&lx_len)) lx_len++;
					taken = 1'b1;
				end else if (close_token(1'b0, r)) begin
					made[n++] = r;
				end
			end
			M_NUMBER: begin
				if (digit_byte(c) || c == CH_DOT) begin
					if (c == CH_DOT) lx_dot = 1'b1;
					if (!(&lx_len)) lx_len++;
					taken = 1'b1;
				end else if (close_token(1'b0, r)) begin
					made[n++] = r;
				end
			end
			default: lx_mode = M_IDLE;
		endcase

		// A byte not absorbed by the current token may start a new one.
		if (!taken && !blank_byte(c)) begin
			lx_start = pos;
			lx_len   = 16'd1;
			if (c == CH_QUOTE) begin
				lx_mode  = M_STRING;
				lx_start = pos + 32'd1;
				lx_len   = 16'd0;
			end else if (opchar_byte(c)) begin
				lx_mode = M_OPER;
			end else if (letter_byte(c) || c == CH_UNDER) begin
				lx_mode = M_IDENT;
				lx_cand = narrow_keywords('1, 16'd0, c);
			end else if (digit_byte(c)) begin
				lx_mode = M_NUMBER;
				lx_dot  = 1'b0;
			end else begin
				made[n++] = token_rec(mark_kind(c), DET_NONE, pos, 16'd1);
			end
		end

		// The end of the text flushes the pending token and clears everything.
		if (end_flag) begin
			if (close_token(1'b1, r)) made[n++] = r;
			lx_mode  = M_IDLE;
			lx_dot   = 1'b0;
			lx_cand  = '0;
			lx_len   = '0;
			lx_start = '0;
			lx_pos   = '0;
		end else begin
			lx_pos = pos + 32'd1;
		end

		for (int i = 0; i < n; i++) begin
			if (i == n - 1) made[i].last = 1'b1;
			token_fifo = {token_fifo, made[i]};
		end
	endfunction

	// Text driver: presents queued bytes, with their idle gaps in front.
	src_byte_t cur_byte;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_ch.valid   <= 1'b0;
			text_ch.char_in <= 8'h00;
			text_ch.is_last <= 1'b0;
			src_busy = 1'b0;
		end else begin
			if (text_ch.valid && text_ch.ready) begin
				lex_byte(cur_byte.ch, cur_byte.end_flag);
				src_busy = 1'b0;
			end
			if (!src_busy && pending.size() > 0) begin
				if (pending[0].gap > 0) begin
					pending[0].gap = pending[0].gap - 1;
				end else begin
					cur_byte = pending.pop_front();
					src_busy = 1'b1;
					text_ch.char_in <= cur_byte.ch;
					text_ch.is_last <= cur_byte.end_flag;
				end
			end
			text_ch.valid <= src_busy;
		end
	end

	task automatic report_bad(input string what);
		mismatches++;
		if (mismatches <= 10) $display("MISMATCH: %s", what);
	endtask

	// Token monitor: stalls at random and checks each word against the oldest expectation.
	int unsigned stall_left = 0;
	int unsigned stretch_left = 0;
	logic        sink_busy = 1'b0;
	tll_result_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (token_ch.valid && token_ch.ready) begin
				if (token_fifo.size() == 0) begin
					report_bad($sformatf("unexpected word kind=%0d start=%0d length=%0d",
						token_ch.token_kind, token_ch.token_start, token_ch.token_length));
				end else begin
					want = token_fifo.pop_front();
					if (token_ch.token_kind !== want.kind || token_ch.kind_detail !== want.detail ||
							token_ch.token_start !== want.start ||
							token_ch.token_length !== want.length ||
							token_ch.last_of_run !== want.last)
						report_bad($sformatf({"expected kind=%0d detail=%0d start=%0d length=%0d ",
							"last=%0d, got kind=%0d detail=%0d start=%0d length=%0d last=%0d"},
							want.kind, want.detail, want.start, want.length, want.last,
							token_ch.token_kind, token_ch.kind_detail, token_ch.token_start,
							token_ch.token_length, token_ch.last_of_run));
				end
				// Stalls come in stretches, with calm stretches in between.
				if (stretch_left == 0) begin
					sink_busy    = $urandom_range(0, 2) != 0;
					stretch_left = $urandom_range(10, 40);
				end else begin
					stretch_left--;
				end
				stall_left = sink_busy ? $urandom_range(0, 12) : 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				token_ch.ready <= 1'b0;
			end else begin
				token_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus building.
	logic        gap_busy = 1'b1;
	int unsigned word_count = 0;

	task automatic queue_byte(input logic [7:0] c, input logic end_flag);
		src_byte_t b;
		b.ch       = c;
		b.end_flag = end_flag;
		b.gap      = gap_busy ? $urandom_range(0, 12) : 0;
		pending    = {pending, b};
		word_count++;
	endtask

	task automatic queue_text(input string s, input logic end_flag);
		for (int i = 0; i < s.len(); i++) queue_byte(s[i], end_flag && i == s.len() - 1);
	endtask

	function automatic logic [7:0] random_blank();
		logic [7:0] c;
		c = 8'h20;
		if ($urandom_range(0, 1)) c = 8'($urandom_range(9, 13));
		return c;
	endfunction

	function automatic logic [7:0] random_ident_char();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0:       c = 8'($urandom_range("A", "Z"));
			1:       c = 8'($urandom_range("0", "9"));
			2:       c = CH_UNDER;
			default: c = 8'($urandom_range("a", "z"));
		endcase
		return c;
	endfunction

	// One well-formed token (or a stray byte) with random content.
	task automatic queue_piece();
		string       kw;
		logic [7:0]  c;
		int unsigned n;
		case ($urandom_range(0, 13))
			0, 1, 2, 3: begin
				kw = kw_word[$urandom_range(0, NKW - 1)];
				case ($urandom_range(0, 5))
					0:       kw = kw.substr(0, kw.len() - 2);
					1:       kw = {kw, string'(random_ident_char())};
					default: ;
				endcase
				if (kw.len() == 0) kw = "_";
				queue_text(kw, 1'b0);
			end
			4, 5: begin
				c = letter_byte(random_ident_char()) ? 8'($urandom_range("a", "z")) : CH_UNDER;
				queue_byte(c, 1'b0);
				n = $urandom_range(0, 7);
				repeat (n) queue_byte(random_ident_char(), 1'b0);
			end
			6, 7: begin
				queue_byte(8'($urandom_range("0", "9")), 1'b0);
				n = $urandom_range(0, 5);
				repeat (n) queue_byte($urandom_range(0, 3) == 0 ? CH_DOT :
					8'($urandom_range("0", "9")), 1'b0);
			end
			8, 9: begin
				queue_byte(CH_QUOTE, 1'b0);
				n = $urandom_range(0, 6);
				repeat (n) begin
					do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
					queue_byte(c, 1'b0);
				end
				if ($urandom_range(0, 7) != 0) queue_byte(CH_QUOTE, 1'b0);
			end
			10: begin
				n = $urandom_range(1, 4);
				repeat (n) queue_byte(oper_set[$urandom_range(0, oper_set.len() - 1)], 1'b0);
			end
			11, 12: queue_byte(mark_chars[$urandom_range(0, mark_chars.len() - 1)], 1'b0);
			default: queue_byte(8'($urandom_range(0, 255)), 1'b0);
		endcase
	endtask

	int unsigned piece_stretch = 0;
	int unsigned end_wait;
	initial begin
		text_ch.valid   = 1'b0;
		text_ch.char_in = 8'h00;
		text_ch.is_last = 1'b0;
		token_ch.ready  = 1'b0;

		// Directed text: a keyword flushed by the end of text, bad bytes, the six marks,
		// a float with several dots, string content with NUL and whitespace, an
		// unused mark, and unterminated strings with and without content.
		queue_text("if", 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_text("(){}=;", 1'b0);
		queue_text("1.2.3 ", 1'b0);
		queue_byte(CH_QUOTE, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h09, 1'b0);
		queue_byte(CH_QUOTE, 1'b0);
		queue_text("a1,", 1'b0);
		queue_text("\"ab", 1'b1);
		queue_text("\"", 1'b1);

		// Random token streams, with adjacent tokens, whitespace and random ends of text.
		word_count = 0;
		while (word_count < 450) begin
			if (piece_stretch == 0) begin
				gap_busy      = $urandom_range(0, 2) != 0;
				piece_stretch = $urandom_range(5, 20);
			end else begin
				piece_stretch--;
			end
			queue_piece();
			if ($urandom_range(0, 24) == 0) begin
				case ($urandom_range(0, 5))
					0:       queue_byte(random_blank(), 1'b1);
					1:       queue_byte(CH_QUOTE, 1'b1);
					2:       queue_byte(8'($urandom_range("0", "9")), 1'b1);
					3:       queue_byte("+", 1'b1);
					4:       queue_byte(CH_SEMI, 1'b1);
					default: queue_byte(random_ident_char(), 1'b1);
				endcase
			end else if ($urandom_range(0, 3) != 0) begin
				n_blanks_loop: repeat ($urandom_range(1, 2)) queue_byte(random_blank(), 1'b0);
			end
		end
		queue_text(" end", 1'b1);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the text to drain and every token to arrive.
		while (pending.size() > 0 || src_busy || text_ch.valid || token_fifo.size() > 0)
			@(posedge clk);
		for (end_wait = 0; end_wait < 16; end_wait++) @(posedge clk);

		if (mismatches == 0 && token_fifo.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(12 * 1500000);
		$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/tll_pkg.sv
hdl/tll_if.sv
hdl/tll_core.sv
hdl/tll_queue.sv
hdl/toy_language_lexer.sv
hdl/tll_checker.sv
tb/toy_language_lexer_tb.sv
